// ===== rtl/lpht_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the linear-probe hash table unit.
// No dependencies; imported by the controller, datapath and top level.
package lpht_pkg;

    localparam int NAME_W      = 64;
    localparam int TEL_W       = 34;
    localparam int KEY_W       = 7;
    localparam int KEY_MODULUS = 100;
    localparam int SUM_W       = 11;
    localparam int RECIP       = 655;
    localparam int RECIP_W     = 10;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = SUM_W + RECIP_W;

    typedef enum logic [1:0]
    {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_UPDATE = 2'd2,
        OP_DELETE = 2'd3
    } op_t;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;

    typedef struct packed
    {
        logic load_in;
        logic clear;
        logic start;
        logic probe;
        logic save_res;
        logic load_out;
        logic out_from_pend;
    } lpht_cmd_t;

    typedef struct packed
    {
        logic hit;
        logic last;
        logic clear_last;
    } lpht_stat_t;

endpackage

// ===== rtl/lpht_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine for the linear-probe hash table unit.
// Depends on lpht_pkg; drives datapath commands and both handshakes.
module lpht_ctrl
    import lpht_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  lpht_stat_t stat,
    output lpht_cmd_t  cmd
);

    typedef enum logic [4:0]
    {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_HASH  = 5'b00100,
        S_PROBE = 5'b01000,
        S_WAIT  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_HASH;
                end
            end
            S_HASH:
            begin
                cmd.start  = 1'b1;
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                cmd.probe = 1'b1;
                if (stat.hit || stat.last)
                begin
                    if (out_free)
                    begin
                        cmd.load_out = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        cmd.save_res = 1'b1;
                        state_next   = S_WAIT;
                    end
                end
            end
            S_WAIT:
            begin
                if (out_free)
                begin
                    cmd.load_out      = 1'b1;
                    cmd.out_from_pend = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/lpht_datapath.sv =====
`timescale 1ns / 1ps
// Datapath for the linear-probe hash table unit: name hash, probe counters,
// slot memories and result registers. Depends on lpht_pkg.
module lpht_datapath
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = 100,
    parameter int NAME_BYTES = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  lpht_cmd_t         cmd,
    output lpht_stat_t        stat,
    input  logic [1:0]        opcode,
    input  logic [NAME_W-1:0] name_chars,
    input  logic [TEL_W-1:0]  telephone,
    output logic [1:0]        status,
    output logic [NAME_W-1:0] found_name,
    output logic [TEL_W-1:0]  found_telephone
);

    localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
    localparam int QUOT_W = PROD_W - RECIP_SHIFT;

    // input registers
    op_t               op_reg;
    logic [NAME_W-1:0] name_reg;
    logic [TEL_W-1:0]  tel_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [KEY_W-1:0]  key_reg;

    // trim and byte sum
    logic [SUM_W-1:0]  sum_next;
    logic [NAME_W-1:0] trim_next;
    logic              stop;
    logic [SUM_W-1:0]  pair_sum [4];
    logic [SUM_W-1:0]  quad_sum [2];

    // key and home index
    logic [PROD_W-1:0] prod;
    logic [QUOT_W-1:0] quot;
    logic [SUM_W-1:0]  rem_raw;
    logic [KEY_W-1:0]  key_next;
    logic [IDX_W-1:0]  home_lut [KEY_MODULUS];
    logic [IDX_W-1:0]  home;

    // probe control
    logic [IDX_W-1:0]  addr_reg;
    logic [IDX_W-1:0]  cmp_addr_reg;
    logic [IDX_W-1:0]  cnt_reg;
    logic [IDX_W-1:0]  clr_cnt_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  addr_inc;

    // slot memories
    logic [KEY_W:0]    key_mem  [TABLE_SIZE];
    logic [NAME_W-1:0] name_mem [TABLE_SIZE];
    logic [TEL_W-1:0]  tel_mem  [TABLE_SIZE];
    logic [KEY_W:0]    key_rd_reg;
    logic [NAME_W-1:0] name_rd_reg;
    logic [TEL_W-1:0]  tel_rd_reg;
    logic              rd_used;
    logic              hit;
    logic              is_insert;
    logic              key_we;
    logic [IDX_W-1:0]  key_waddr;
    logic [KEY_W:0]    key_wdata;
    logic              name_we;
    logic              tel_we;

    // results
    logic [1:0]        res_status;
    logic [NAME_W-1:0] res_name;
    logic [TEL_W-1:0]  res_tel;
    logic [1:0]        pend_status_reg;
    logic [NAME_W-1:0] pend_name_reg;
    logic [TEL_W-1:0]  pend_tel_reg;
    logic [1:0]        status_reg;
    logic [NAME_W-1:0] name_out_reg;
    logic [TEL_W-1:0]  tel_out_reg;

    always_comb
    begin
        trim_next = '0;
        stop      = 1'b0;
        for (int b = 0; b < NAME_BYTES; b++)
        begin
            if (!stop)
            begin
                if (name_chars[8*b +: 8] == 8'd0)
                begin
                    stop = 1'b1;
                end
                else
                begin
                    trim_next[8*b +: 8] = name_chars[8*b +: 8];
                end
            end
        end
        for (int p = 0; p < 4; p++)
        begin
            pair_sum[p] = SUM_W'(trim_next[16*p +: 8]) + SUM_W'(trim_next[16*p+8 +: 8]);
        end
        quad_sum[0] = pair_sum[0] + pair_sum[1];
        quad_sum[1] = pair_sum[2] + pair_sum[3];
        sum_next    = quad_sum[0] + quad_sum[1];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg   <= op_t'(opcode);
            name_reg <= trim_next;
            tel_reg  <= telephone;
            sum_reg  <= sum_next;
        end
        if (cmd.start)
        begin
            key_reg <= key_next;
        end
    end

    assign prod    = PROD_W'(sum_reg) * PROD_W'(RECIP);
    assign quot    = prod[PROD_W-1:RECIP_SHIFT];
    assign rem_raw = sum_reg - SUM_W'(SUM_W'(quot) * SUM_W'(KEY_MODULUS));
    assign key_next = (rem_raw >= SUM_W'(KEY_MODULUS)) ?
                      KEY_W'(rem_raw - SUM_W'(KEY_MODULUS)) : KEY_W'(rem_raw);

    for (genvar k = 0; k < KEY_MODULUS; k++)
    begin : g_home
        localparam int HOME_K = k % TABLE_SIZE;
        assign home_lut[k] = IDX_W'(HOME_K);
    end

    assign home     = home_lut[key_next];
    assign rd_addr  = cmd.start ? home : addr_reg;
    assign addr_inc = (rd_addr == LAST_IDX) ? '0 : rd_addr + IDX_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg     <= '0;
            cmp_addr_reg <= '0;
            cnt_reg      <= '0;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.start || cmd.probe)
            begin
                addr_reg     <= addr_inc;
                cmp_addr_reg <= rd_addr;
            end
            if (cmd.start)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.probe)
            begin
                cnt_reg <= cnt_reg + IDX_W'(1);
            end
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end
        end
    end

    assign is_insert = (op_reg == OP_INSERT);
    assign rd_used   = key_rd_reg[KEY_W];
    assign hit       = is_insert ? !rd_used :
                       (rd_used && (key_rd_reg[KEY_W-1:0] == key_reg));

    assign key_we    = cmd.clear ||
                       (cmd.probe && hit && (is_insert || (op_reg == OP_DELETE)));
    assign key_waddr = cmd.clear ? clr_cnt_reg : cmp_addr_reg;
    assign key_wdata = (!cmd.clear && is_insert) ? {1'b1, key_reg} : '0;
    assign name_we   = cmd.probe && hit && is_insert;
    assign tel_we    = cmd.probe && hit && (is_insert || (op_reg == OP_UPDATE));

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_waddr] <= key_wdata;
        end
        key_rd_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (name_we)
        begin
            name_mem[cmp_addr_reg] <= name_reg;
        end
        name_rd_reg <= name_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (tel_we)
        begin
            tel_mem[cmp_addr_reg] <= tel_reg;
        end
        tel_rd_reg <= tel_mem[rd_addr];
    end

    always_comb
    begin
        res_status = is_insert ? STAT_FULL : STAT_NOT_FOUND;
        res_name   = '0;
        res_tel    = '0;
        if (hit)
        begin
            res_status = STAT_OK;
            if (!is_insert)
            begin
                res_name = name_rd_reg;
                res_tel  = (op_reg == OP_UPDATE) ? tel_reg : tel_rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.save_res)
        begin
            pend_status_reg <= res_status;
            pend_name_reg   <= res_name;
            pend_tel_reg    <= res_tel;
        end
        if (cmd.load_out)
        begin
            status_reg   <= cmd.out_from_pend ? pend_status_reg : res_status;
            name_out_reg <= cmd.out_from_pend ? pend_name_reg : res_name;
            tel_out_reg  <= cmd.out_from_pend ? pend_tel_reg : res_tel;
        end
    end

    assign stat.hit        = hit;
    assign stat.last       = (cnt_reg == LAST_IDX);
    assign stat.clear_last = (clr_cnt_reg == LAST_IDX);

    assign status          = status_reg;
    assign found_name      = name_out_reg;
    assign found_telephone = tel_out_reg;

endmodule

// ===== rtl/linear_probe_hash_table_unit.sv =====
`timescale 1ns / 1ps
// A request is registered on acceptance, one transaction at a time; its key and
// home slot are computed as the first read issues, then 1..TABLE_SIZE slots are
// probed, one slot per cycle through the registered read port of the slot memories,
// until a hit or the last slot. Reset: after rst_n is released a clearing pass
// writes every slot empty; in_stall stays high until it finishes.
module linear_probe_hash_table_unit
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = 100,
    parameter int NAME_BYTES = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        opcode,
    input  logic [NAME_W-1:0] name_chars,
    input  logic [TEL_W-1:0]  telephone,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [NAME_W-1:0] found_name,
    output logic [TEL_W-1:0]  found_telephone
);

    lpht_cmd_t  cmd;
    lpht_stat_t stat;

    lpht_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    lpht_datapath #(
        .TABLE_SIZE (TABLE_SIZE),
        .NAME_BYTES (NAME_BYTES)
    ) u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .opcode          (opcode),
        .name_chars      (name_chars),
        .telephone       (telephone),
        .status          (status),
        .found_name      (found_name),
        .found_telephone (found_telephone)
    );

endmodule
